// File: hdl/aes_cbe_pkg.sv
// Shared AES-128 tables and round functions for the counter-mode byte editor.
`timescale 1ns / 1ps

package aes_cbe_pkg;

    localparam int NUM_ROUNDS = 10;

    localparam logic [1:0] CFG_KEY_LOW   = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH  = 2'd1;
    localparam logic [1:0] CFG_NONCE     = 2'd2;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [0:NUM_ROUNDS-1] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    typedef logic [127:0] t_block;

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns
    function automatic t_block enc_round(input t_block s, input logic last);
        t_block t;
        t_block m;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)&3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return last ? t : m;
    endfunction

    // One step of the key schedule: next round key from the previous one
    function automatic t_block key_step(input t_block rk, input logic [7:0] rc);
        logic [31:0] t;
        t_block n;
        t = {SBOX[rk[103:96]], SBOX[rk[127:120]], SBOX[rk[119:112]],
             SBOX[rk[111:104]] ^ rc};
        n[31:0]   = rk[31:0]   ^ t;
        n[63:32]  = rk[63:32]  ^ n[31:0];
        n[95:64]  = rk[95:64]  ^ n[63:32];
        n[127:96] = rk[127:96] ^ n[95:64];
        return n;
    endfunction

endpackage

// File: hdl/aes_ctr_byte_edit.sv
// Pipeline: an AddRoundKey input stage, a stage per AES round, then an output byte register.
// One byte per cycle unless output stalls; one AES round and key step per round stage.
// Stages with empty slots advance under a downstream stall, so bubbles are absorbed.
// Reset (synchronous, active low) clears all valid bits and the key and nonce to zero.
// Round keys travel with each item, so configuration takes effect on the next transfer.
`timescale 1ns / 1ps

module aes_ctr_byte_edit #(
    parameter int POSITION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [63:0]              i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [POSITION_BITS-1:0] i_byte_position,
    input  logic [7:0]               i_cipher_byte,
    input  logic [7:0]               i_plain_byte,
    input  logic                     i_replace,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_out_byte
);

    localparam int NR    = aes_cbe_pkg::NUM_ROUNDS;
    localparam int LAST  = NR + 1;

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic [63:0] r_nonce;

    logic [LAST:0]           r_valid;
    logic [LAST:0]           ld;
    aes_cbe_pkg::t_block     r_state [0:NR];
    aes_cbe_pkg::t_block     r_rk    [0:NR];
    aes_cbe_pkg::t_block     n_state [0:NR];
    aes_cbe_pkg::t_block     n_rk    [0:NR];
    logic [3:0]              r_pos    [0:NR];
    logic [7:0]              r_plain  [0:NR];
    logic [7:0]              r_cipher [0:NR];
    logic                    r_repl   [0:NR];
    logic [7:0]              r_out;
    logic [7:0]              n_out;
    logic [7:0]              ks_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_nonce    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aes_cbe_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                aes_cbe_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                aes_cbe_pkg::CFG_NONCE:    r_nonce    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ld[LAST] = !r_valid[LAST] || i_out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            ld[k] = !r_valid[k] || ld[k+1];
        end
    end

    assign o_in_ready  = ld[0];
    assign o_out_valid = r_valid[LAST];
    assign o_out_byte  = r_out;

    always_comb begin
        n_rk[0]    = {r_key_high, r_key_low};
        n_state[0] = {64'(i_byte_position[POSITION_BITS-1:4]), r_nonce} ^ n_rk[0];
        for (int r = 1; r <= NR; r++) begin
            n_rk[r]    = aes_cbe_pkg::key_step(r_rk[r-1], aes_cbe_pkg::RCON[r-1]);
            n_state[r] = aes_cbe_pkg::enc_round(r_state[r-1], r == NR) ^ n_rk[r];
        end
        ks_byte = r_state[NR][{r_pos[NR], 3'b000} +: 8];
        n_out   = r_repl[NR] ? (ks_byte ^ r_plain[NR]) : r_cipher[NR];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (ld[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (ld[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_state[0]  <= n_state[0];
            r_rk[0]     <= n_rk[0];
            r_pos[0]    <= i_byte_position[3:0];
            r_plain[0]  <= i_plain_byte;
            r_cipher[0] <= i_cipher_byte;
            r_repl[0]   <= i_replace;
        end
        for (int r = 1; r <= NR; r++) begin
            if (ld[r]) begin
                r_state[r]  <= n_state[r];
                r_rk[r]     <= n_rk[r];
                r_pos[r]    <= r_pos[r-1];
                r_plain[r]  <= r_plain[r-1];
                r_cipher[r] <= r_cipher[r-1];
                r_repl[r]   <= r_repl[r-1];
            end
        end
        if (ld[LAST]) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/aes_cbe_chk.sv
// Port-level checker for the counter-mode byte editor, bound to the top level.
`timescale 1ns / 1ps

module aes_cbe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("output changed during stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_full_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

endmodule

bind aes_ctr_byte_edit aes_cbe_chk u_chk (.*);

// File: sim/tb.sv
// Self-checking testbench for the AES-128 counter-mode byte editor.
`timescale 1ns / 1ps

class edit_scoreboard;
    logic [7:0] pending_bytes[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    function void note_input(logic [7:0] predicted);
        pending_bytes.push_back(predicted);
    endfunction

    function void check_output(logic [7:0] actual);
        logic [7:0] want;
        if (pending_bytes.size() == 0) begin
            $error("out_byte: no expected value, actual %02h", actual);
            errors++;
        end else begin
            want = pending_bytes.pop_front();
            if (want !== actual) begin
                $error("out_byte: expected %02h, actual %02h", want, actual);
                errors++;
            end
        end
    endfunction
endclass

module tb;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_byte_position;
    logic [7:0]  i_cipher_byte;
    logic [7:0]  i_plain_byte;
    logic        i_replace;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;

    logic [63:0] key_lo_q, key_hi_q, nonce_q;
    edit_scoreboard sb;
    bit          sink_busy;
    bit          hold_sink;
    int          hold_cycles;

    aes_ctr_byte_edit #(.POSITION_BITS(32)) i_dut (.*);

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #100ms;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] keystream_byte(logic [31:0] pos);
        logic [7:0] sb_tab [0:255];
        logic [7:0] rc [0:9];
        logic [7:0] k [0:15];
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [7:0] f, a0, a1, a2, a3, al;
        logic [63:0] blk;
        sb_tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
            8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
            8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,
            8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,
            8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
            8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
            8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,
            8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
            8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,
            8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
            8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
            8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,
            8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,
            8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
            8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,
            8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
            8'hb0,8'h54,8'hbb,8'h16};
        rc = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
        blk = {36'd0, pos[31:4]};
        for (int i = 0; i < 8; i++) begin
            k[i] = key_lo_q[8*i +: 8];
            k[8+i] = key_hi_q[8*i +: 8];
            s[i] = nonce_q[8*i +: 8] ^ k[i];
            s[8+i] = blk[8*i +: 8] ^ k[8+i];
        end
        for (int r = 1; r <= 10; r++) begin
            f = k[12];
            k[0] = k[0] ^ sb_tab[k[13]] ^ rc[r-1];
            k[1] = k[1] ^ sb_tab[k[14]];
            k[2] = k[2] ^ sb_tab[k[15]];
            k[3] = k[3] ^ sb_tab[f];
            for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i+4*c] = sb_tab[s[i+4*((c+i)&3)]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
        end
        return s[pos[3:0]];
    endfunction

    function automatic logic [7:0] mul2(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            aes_cbe_pkg::CFG_KEY_LOW:  key_lo_q = val;
            aes_cbe_pkg::CFG_KEY_HIGH: key_hi_q = val;
            aes_cbe_pkg::CFG_NONCE:    nonce_q = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_byte(logic [31:0] pos, logic [7:0] cb, logic [7:0] pb, logic rep,
                             bit gaps);
        int gap;
        gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16)) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_byte_position <= pos;
        i_cipher_byte   <= cb;
        i_plain_byte    <= pb;
        i_replace       <= rep;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(rep ? keystream_byte(pos) ^ pb : cb);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic feed_bytes(int count, bit gaps);
        logic [31:0] pos;
        pos = $urandom;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) pos = $urandom;
            else pos = pos + 1;
            send_byte(pos, 8'($urandom), 8'($urandom), $urandom_range(0, 4) != 0, gaps);
        end
    endtask

    // receiver: random stalls plus one long hold
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) sb.check_output(o_out_byte);
    end

    initial begin
        int w;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_sink) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_sink = 1'b0;
            end else begin
                w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
                if (sink_busy && w != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [63:0] v;
        sb = new();
        sink_busy = 1'b0;
        hold_sink = 1'b0;
        key_lo_q = '0; key_hi_q = '0; nonce_q = '0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0; i_cfg_index <= '0; i_cfg_data <= '0;
        i_in_valid <= 1'b0; i_byte_position <= '0; i_cipher_byte <= '0;
        i_plain_byte <= '0; i_replace <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key and nonce, extremes of position and bytes
        send_byte(32'h0, 8'h00, 8'h00, 1'b1, 0);
        send_byte(32'hffff_ffff, 8'hff, 8'hff, 1'b1, 0);
        send_byte(32'h0000_000f, 8'h5a, 8'ha5, 1'b1, 0);
        send_byte(32'h0000_0010, 8'h5a, 8'ha5, 1'b1, 0);
        send_byte(32'h1234_5678, 8'hff, 8'h00, 1'b0, 0);
        send_byte(32'hffff_fff0, 8'h00, 8'hff, 1'b0, 0);
        drain();

        // standard test vector key, then all-ones key and nonce
        write_reg(aes_cbe_pkg::CFG_KEY_LOW, 64'h0f0e_0d0c_0b0a_0908 ^
                  64'h0706_0504_0302_0100 ^ 64'h0f0e_0d0c_0b0a_0908);
        write_reg(aes_cbe_pkg::CFG_KEY_HIGH, 64'h0f0e_0d0c_0b0a_0908);
        write_reg(aes_cbe_pkg::CFG_NONCE, 64'h8877_6655_4433_2211);
        write_reg(CFG_SPARE, 64'hdead_beef_dead_beef);
        for (int i = 0; i < 16; i++) send_byte(32'(i), 8'h00, 8'h00, 1'b1, 0);
        drain();
        write_reg(aes_cbe_pkg::CFG_KEY_LOW, '1);
        write_reg(aes_cbe_pkg::CFG_KEY_HIGH, '1);
        write_reg(aes_cbe_pkg::CFG_NONCE, '1);
        send_byte(32'hffff_ffff, 8'h3c, 8'hc3, 1'b1, 0);
        send_byte(32'h8000_0000, 8'h3c, 8'hc3, 1'b1, 0);
        drain();

        sink_busy = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            v = {$urandom, $urandom};
            write_reg(aes_cbe_pkg::CFG_KEY_LOW, v);
            v = {$urandom, $urandom};
            write_reg(aes_cbe_pkg::CFG_KEY_HIGH, v);
            v = (ph == 5) ? 64'h0 : {$urandom, $urandom};
            write_reg(aes_cbe_pkg::CFG_NONCE, v);
            if (ph == 1) begin
                hold_cycles = 300;
                hold_sink = 1'b1;
                feed_bytes(60, 0);
            end
            feed_bytes(210, ph != 2);
            drain();
        end

        if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/aes_cbe_pkg.sv
hdl/aes_ctr_byte_edit.sv
hdl/aes_cbe_chk.sv
sim/tb.sv
